>>> hw/rtl/hll_pkg.sv
// Shared constants, command codes, request type and rank weight function for the sketch update block.
package hll_pkg;

	localparam int MAX_P     = 18;
	localparam int RANK_W    = 6;
	localparam int CNT_W     = 9;
	localparam int FRAC_BITS = 45;
	localparam int SUM_OUT_W = 58;
	localparam int HASH_W    = 64;

	// Input command codes.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef logic [RANK_W-1:0] rank_t;

	typedef struct packed {
		logic             clr;
		logic             upd;
		logic [MAX_P-1:0] idx;
		rank_t            rank;
	} hll_req_t;

	// Weight 2^-rank in fixed point with FRAC_BITS fraction bits; tiny terms drop to zero.
	function automatic logic [FRAC_BITS:0] term(input rank_t v);
		logic [FRAC_BITS:0] t;
		t = '0;
		if (v <= rank_t'(FRAC_BITS)) begin
			t = (FRAC_BITS+1)'(1) << (rank_t'(FRAC_BITS) - v);
		end
		return t;
	endfunction

endpackage

>>> hw/rtl/hyperloglog_sketch_update.sv
// Top level of the sketch update block: explicit hash list, promotion sequencer and output word.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  input   | in        | in_valid / in_stall   | command, hash
//  output  | out       | out_valid / out_stall | mode, explicit_count, zero_count,
//          |           |                       | harmonic_sum, reg_index, reg_value
//  config  | in        | cfg_wr_en             | cfg_wr_data (explicit limit)
//
// One word is worked on at a time. A register-mode add passes through the rank step (the
// byte-wide rank unit), the rank store read-modify-write, the load of the output register and
// the return to idle. The explicit-list search reads and compares each stored hash in turn; a
// promotion ranks and stores each stored hash in turn. A clear, and the period after reset,
// sweep all 2^PRECISION registers of the rank store with in_stall high. A finished word waits
// in the output register while out_stall is high.
module hyperloglog_sketch_update #(
	parameter int PRECISION  = 12,
	parameter int LIST_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hll_pkg::CNT_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [hll_pkg::HASH_W-1:0]     hash,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           mode,
	output logic [hll_pkg::CNT_W-1:0]      explicit_count,
	output logic [PRECISION:0]             zero_count,
	output logic [hll_pkg::SUM_OUT_W-1:0]  harmonic_sum,
	output logic [PRECISION-1:0]           reg_index,
	output logic [hll_pkg::RANK_W-1:0]     reg_value
);
	import hll_pkg::*;

	localparam int NREGS = 1 << PRECISION;
	localparam int AW    = $clog2(LIST_DEPTH);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_RANK, S_SRD, S_SCMP, S_DEC,
		S_PRD, S_PSTART, S_PRANK, S_PUPD, S_FIN, S_FWAIT, S_EMIT
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       limit_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       k_q;
	logic                   mode_q;
	logic                   cmd_q;
	logic [HASH_W-1:0]      hash_q;
	logic [PRECISION-1:0]   ri_q;
	rank_t                  rv_q;
	logic [HASH_W-1:0]      lst_rd_q;
	logic [HASH_W-1:0]      lst [LIST_DEPTH];

	logic                   out_valid_q;
	logic                   out_mode_q;
	logic [CNT_W-1:0]       out_count_q;
	logic [PRECISION:0]     out_zeros_q;
	logic [SUM_OUT_W-1:0]   out_sum_q;
	logic [PRECISION-1:0]   out_ri_q;
	rank_t                  out_rv_q;

	logic                   accept;
	logic [CNT_W-1:0]       lim;
	logic                   append;
	logic                   out_free;

	logic                   rank_start;
	logic [HASH_W-1:0]      rank_hash;
	logic                   rank_busy;
	logic [PRECISION-1:0]   rank_idx;
	rank_t                  rank_val;

	hll_req_t               req;
	logic                   regs_busy;
	logic [PRECISION:0]     regs_zeros;
	logic [PRECISION+45:0]  regs_sum;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The usable list length is the written limit, capped at the list memory depth.
	assign lim    = (limit_q > CNT_W'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH) : limit_q;
	assign append = (state_q == S_DEC) && (count_q < lim);

	// The rank unit serves the incoming hash and, during promotion, each stored hash.
	assign rank_start = (accept && !command) || (state_q == S_PSTART);
	assign rank_hash  = (state_q == S_IDLE) ? hash : lst_rd_q;

	hll_rank #(.PRECISION(PRECISION)) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rank_start),
		.hash   (rank_hash),
		.busy   (rank_busy),
		.idx    (rank_idx),
		.rank   (rank_val)
	);

	// Requests to the rank store: a clear at accept, an update when a rank is ready.
	always_comb begin
		req      = '0;
		req.clr  = accept && command;
		if (state_q == S_FIN) begin
			req.upd  = 1'b1;
			req.idx  = MAX_P'(ri_q);
			req.rank = rv_q;
		end else if ((state_q == S_PRANK && !rank_busy) ||
		             (state_q == S_RANK && !rank_busy && mode_q)) begin
			req.upd  = 1'b1;
			req.idx  = MAX_P'(rank_idx);
			req.rank = rank_val;
		end
	end

	hll_regs #(.PRECISION(PRECISION)) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.busy   (regs_busy),
		.zeros  (regs_zeros),
		.sum    (regs_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			limit_q     <= CNT_W'(256);
			count_q     <= '0;
			k_q         <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			// A taken word frees the register unless a new word is loaded in the same cycle.
			if (out_valid_q && !out_stall && state_q != S_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				S_INIT: if (!regs_busy) state_q <= S_IDLE;
				S_IDLE: begin
					if (accept) begin
						if (command) begin
							mode_q  <= 1'b0;
							count_q <= '0;
							state_q <= S_CLR;
						end else begin
							state_q <= S_RANK;
						end
					end
				end
				S_CLR: if (!regs_busy) state_q <= S_EMIT;
				S_RANK: begin
					if (!rank_busy) begin
						k_q <= '0;
						if (mode_q) state_q <= S_FWAIT;
						else if (count_q == '0) state_q <= S_DEC;
						else state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (lst_rd_q == hash_q) begin
						state_q <= S_EMIT;
					end else if (k_q + 1'b1 == count_q) begin
						state_q <= S_DEC;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_DEC: begin
					k_q <= '0;
					if (append) begin
						count_q <= count_q + 1'b1;
						state_q <= S_EMIT;
					end else if (count_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PRD;
					end
				end
				S_PRD:    state_q <= S_PSTART;
				S_PSTART: state_q <= S_PRANK;
				S_PRANK:  if (!rank_busy) state_q <= S_PUPD;
				S_PUPD: begin
					if (!regs_busy) begin
						if (k_q + 1'b1 == count_q) begin
							state_q <= S_FIN;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_PRD;
						end
					end
				end
				S_FIN: begin
					count_q <= '0;
					mode_q  <= 1'b1;
					state_q <= S_FWAIT;
				end
				S_FWAIT: if (!regs_busy) state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: the accepted word, the hash list and the output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			hash_q <= hash;
			if (command) begin
				ri_q <= '0;
				rv_q <= '0;
			end
		end
		if (state_q == S_RANK && !rank_busy && !cmd_q) begin
			ri_q <= rank_idx;
			rv_q <= rank_val;
		end
		lst_rd_q <= lst[k_q[AW-1:0]];
		if (append) lst[count_q[AW-1:0]] <= hash_q;
		if (state_q == S_EMIT && out_free) begin
			out_mode_q  <= mode_q;
			out_count_q <= count_q;
			out_zeros_q <= regs_zeros;
			out_sum_q   <= SUM_OUT_W'(regs_sum);
			out_ri_q    <= ri_q;
			out_rv_q    <= rv_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode           = out_mode_q;
	assign explicit_count = out_count_q;
	assign zero_count     = out_zeros_q;
	assign harmonic_sum   = out_sum_q;
	assign reg_index      = out_ri_q;
	assign reg_value      = out_rv_q;

	// Only one word is in flight: an accepted word keeps the input stalled next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input accepted while a word was in flight");

	// Register mode always reports an empty explicit list.
	a_mode_list: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mode && explicit_count != '0))
		else $error("register mode reported with a nonempty list");

	// The list never holds more hashes than the list memory.
	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_DEPTH))
		else $error("explicit list count beyond list depth");

	// The zero count never exceeds the number of registers.
	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		regs_zeros <= (PRECISION+1)'(NREGS))
		else $error("zero register count beyond register count");

endmodule

>>> hw/rtl/hll_rank.sv
// Iterative rank unit: register index and leading-zero rank of one hash, a byte per cycle.
module hll_rank #(
	parameter int PRECISION = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hll_pkg::HASH_W-1:0]  hash,
	output logic                        busy,
	output logic [PRECISION-1:0]        idx,
	output logic [hll_pkg::RANK_W-1:0]  rank
);
	import hll_pkg::*;

	localparam int    RW        = HASH_W - PRECISION;
	localparam rank_t RANK_ZERO = rank_t'(65 - PRECISION);

	logic                 busy_q;
	logic [RW-1:0]        rest_q;
	rank_t                n_q;
	rank_t                rank_q;
	logic [PRECISION-1:0] idx_q;
	logic [7:0]           top8;

	function automatic logic [3:0] lz8(input logic [7:0] b);
		logic [3:0] n;
		logic       hit;
		n   = 4'd0;
		hit = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!hit) begin
				if (b[i]) hit = 1'b1;
				else n = n + 4'd1;
			end
		end
		return n;
	endfunction

	assign top8 = rest_q[RW-1 -: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (rest_q == '0 || top8 != 8'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rest_q <= hash[RW-1:0];
			n_q    <= '0;
			idx_q  <= hash[HASH_W-1 -: PRECISION];
		end else if (busy_q) begin
			if (rest_q == '0) begin
				rank_q <= RANK_ZERO;
			end else if (top8 != 8'd0) begin
				rank_q <= n_q + rank_t'(lz8(top8)) + rank_t'(1);
			end else begin
				rest_q <= rest_q << 8;
				n_q    <= n_q + rank_t'(8);
			end
		end
	end

	assign busy = busy_q;
	assign idx  = idx_q;
	assign rank = rank_q;

endmodule

>>> hw/rtl/hll_regs.sv
// Dense rank store with clearing sweep, read-modify-write update, zero count and harmonic sum.
module hll_regs #(
	parameter int PRECISION = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hll_pkg::hll_req_t         req,
	output logic                      busy,
	output logic [PRECISION:0]        zeros,
	output logic [PRECISION+45:0]     sum
);
	import hll_pkg::*;

	localparam int NREGS = 1 << PRECISION;
	localparam int SW    = PRECISION + 46;

	typedef enum logic [2:0] {R_CLR, R_IDLE, R_RD, R_CMP, R_ADD} rstate_t;

	rstate_t              state_q;
	logic [PRECISION-1:0] addr_q;
	logic [PRECISION:0]   zeros_q;
	logic [SW-1:0]        sum_q;
	rank_t                rank_q;
	rank_t                rd_q;
	rank_t                mem [NREGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_CLR;
			addr_q  <= '0;
			zeros_q <= (PRECISION+1)'(NREGS);
			sum_q   <= SW'(NREGS) << FRAC_BITS;
		end else begin
			case (state_q)
				R_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == '1) begin
						state_q <= R_IDLE;
						zeros_q <= (PRECISION+1)'(NREGS);
						sum_q   <= SW'(NREGS) << FRAC_BITS;
					end
				end
				R_IDLE: begin
					if (req.clr) begin
						state_q <= R_CLR;
						addr_q  <= '0;
					end else if (req.upd) begin
						state_q <= R_RD;
						addr_q  <= req.idx[PRECISION-1:0];
					end
				end
				R_RD: state_q <= R_CMP;
				R_CMP: begin
					if (rank_q > rd_q) begin
						if (rd_q == '0) zeros_q <= zeros_q - 1'b1;
						sum_q   <= sum_q - SW'(term(rd_q));
						state_q <= R_ADD;
					end else begin
						state_q <= R_IDLE;
					end
				end
				R_ADD: begin
					sum_q   <= sum_q + SW'(term(rank_q));
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == R_IDLE && req.upd) rank_q <= req.rank;
		rd_q <= mem[addr_q];
		if (state_q == R_CLR) begin
			mem[addr_q] <= '0;
		end else if (state_q == R_CMP && rank_q > rd_q) begin
			mem[addr_q] <= rank_q;
		end
	end

	assign busy  = (state_q != R_IDLE);
	assign zeros = zeros_q;
	assign sum   = sum_q;

endmodule
